// ----- design/wgp_pkg.sv -----
// ----------------------------------------------------------------------------
// wgp_pkg
// shared types and constants of the windowed grid projection block
// ----------------------------------------------------------------------------
package wgp_pkg;

    // configuration register geometry
    localparam int CFG_W     = 6;
    localparam int CFG_IDX_W = 3;

    // result field widths
    localparam int BIN_W      = 5;
    localparam int SUM_W      = 42;
    localparam int OUT_DATA_W = ((BIN_W + SUM_W + 7) / 8) * 8;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_X_BINS       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_Y_BINS       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PHI_X_FIRST  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PHI_X_LAST   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ETA_Y_FIRST  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ETA_Y_LAST   = 3'd5;

    // register reset values
    localparam logic [CFG_W-1:0] RST_X_BINS      = 6'd20;
    localparam logic [CFG_W-1:0] RST_Y_BINS      = 6'd20;
    localparam logic [CFG_W-1:0] RST_PHI_X_FIRST = 6'd0;
    localparam logic [CFG_W-1:0] RST_PHI_X_LAST  = 6'd10;
    localparam logic [CFG_W-1:0] RST_ETA_Y_FIRST = 6'd6;
    localparam logic [CFG_W-1:0] RST_ETA_Y_LAST  = 6'd10;

    typedef struct packed {
        logic [CFG_W-1:0] x_bins;
        logic [CFG_W-1:0] y_bins;
        logic [CFG_W-1:0] phi_x_first;
        logic [CFG_W-1:0] phi_x_last;
        logic [CFG_W-1:0] eta_y_first;
        logic [CFG_W-1:0] eta_y_last;
    } cfg_regs_t;

endpackage

// ----- design/wgp_ram.sv -----
// ----------------------------------------------------------------------------
// wgp_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module wgp_ram #(
    parameter int WIDTH = 42,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read returns the old contents on a same-address write
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- design/wgp_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// wgp_cfg_regs
// configuration register file of the windowed grid projection
// ----------------------------------------------------------------------------
module wgp_cfg_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [wgp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [wgp_pkg::CFG_W-1:0]      cfg_data,
    output wgp_pkg::cfg_regs_t             cfg_regs
);

    wgp_pkg::cfg_regs_t regs_reg;

    assign cfg_ready = 1'b1;
    assign cfg_regs  = regs_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            regs_reg.x_bins      <= wgp_pkg::RST_X_BINS;
            regs_reg.y_bins      <= wgp_pkg::RST_Y_BINS;
            regs_reg.phi_x_first <= wgp_pkg::RST_PHI_X_FIRST;
            regs_reg.phi_x_last  <= wgp_pkg::RST_PHI_X_LAST;
            regs_reg.eta_y_first <= wgp_pkg::RST_ETA_Y_FIRST;
            regs_reg.eta_y_last  <= wgp_pkg::RST_ETA_Y_LAST;
        end else if (cfg_valid) begin
            case (cfg_index)
                wgp_pkg::REG_X_BINS:      regs_reg.x_bins      <= cfg_data;
                wgp_pkg::REG_Y_BINS:      regs_reg.y_bins      <= cfg_data;
                wgp_pkg::REG_PHI_X_FIRST: regs_reg.phi_x_first <= cfg_data;
                wgp_pkg::REG_PHI_X_LAST:  regs_reg.phi_x_last  <= cfg_data;
                wgp_pkg::REG_ETA_Y_FIRST: regs_reg.eta_y_first <= cfg_data;
                wgp_pkg::REG_ETA_Y_LAST:  regs_reg.eta_y_last  <= cfg_data;
                default: ;
            endcase
        end
    end

endmodule

// ----- design/windowed_grid_projection.sv -----
// ----------------------------------------------------------------------------
// windowed_grid_projection
// windowed x and y projections of a streamed 2d grid of signed q16.16 cells
// ----------------------------------------------------------------------------
// usage:
//   cells of one grid enter on the s_ channel, x outer and y inner, one item
//   per cycle while s_tready is high. a cell whose 1-based row lies in the
//   eta window is added to its column sum; a cell whose 1-based column lies
//   in the phi window is added to its row sum. the sums live in two 32-entry
//   rams (read as a cell is taken, added to and written back in the next
//   cycle, with forwarding of the previous write when the same entry comes
//   back at once). after the final cell of a grid, s_tready drops, a flush
//   state lets the last write land, then nx column sums (m_tuser low) and ny
//   row sums (m_tuser high) leave on the m_ channel; m_tlast marks the last
//   row sum. each result passes a ram read, an output load and a handshake,
//   and the sequencer just waits while the receiver holds m_tready low. the
//   next grid is taken only after the burst.
//   configuration writes go on the cfg_ channel, always ready, and are meant
//   for idle time only. reset restores the register defaults, the grid
//   position and marks every ram entry empty (no clearing pass needed).
// ----------------------------------------------------------------------------
module windowed_grid_projection #(
    parameter int MAX_BINS    = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input cells
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [((VALUE_WIDTH+7)/8)*8-1:0]  s_tdata,   // cell_value
    // projection results
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [wgp_pkg::OUT_DATA_W-1:0]    m_tdata,   // bin_index, sum
    output logic                              m_tuser,   // axis
    output logic                              m_tlast,
    // configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [wgp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [wgp_pkg::CFG_W-1:0]         cfg_data
);

    localparam int IDX_W = $clog2(MAX_BINS);
    localparam int CNT_W = $clog2(MAX_BINS + 1);
    localparam int CMP_W = ((CNT_W > wgp_pkg::CFG_W) ? CNT_W : wgp_pkg::CFG_W) + 1;
    localparam int SUM_W = wgp_pkg::SUM_W;
    localparam int PAD_W = wgp_pkg::OUT_DATA_W - wgp_pkg::BIN_W - SUM_W;

    // sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;  // taking cells
    localparam logic [2:0] ST_FLUSH = 3'd1;  // final cell write lands
    localparam logic [2:0] ST_RD    = 3'd2;  // read one sum
    localparam logic [2:0] ST_LD    = 3'd3;  // load the output register
    localparam logic [2:0] ST_SEND  = 3'd4;  // wait for the receiver

    wgp_pkg::cfg_regs_t cfg;

    wgp_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_regs  (cfg)
    );

    // effective bin counts: zero acts as one, too large clips to the store
    logic [CMP_W-1:0] nx, ny;

    always_comb begin
        if (cfg.x_bins == '0) begin
            nx = CMP_W'(1);
        end else if (CMP_W'(cfg.x_bins) > CMP_W'(MAX_BINS)) begin
            nx = CMP_W'(MAX_BINS);
        end else begin
            nx = CMP_W'(cfg.x_bins);
        end
        if (cfg.y_bins == '0) begin
            ny = CMP_W'(1);
        end else if (CMP_W'(cfg.y_bins) > CMP_W'(MAX_BINS)) begin
            ny = CMP_W'(MAX_BINS);
        end else begin
            ny = CMP_W'(cfg.y_bins);
        end
    end

    logic [2:0]       state_reg, state_next;
    logic [IDX_W-1:0] x_pos_reg, y_pos_reg;

    // stage 1: cell whose sums are being read this cycle
    logic                          s1_valid_reg;
    logic [IDX_W-1:0]              s1_xa_reg, s1_ya_reg;
    logic                          s1_x_en_reg, s1_y_en_reg;
    logic signed [VALUE_WIDTH-1:0] s1_value_reg;

    // last write of each ram, for an entry read in the same cycle
    logic             fwdx_valid_reg, fwdy_valid_reg;
    logic [IDX_W-1:0] fwdx_addr_reg, fwdy_addr_reg;
    logic [SUM_W-1:0] fwdx_data_reg, fwdy_data_reg;

    // entry-written flags; an empty entry reads as zero
    logic [MAX_BINS-1:0] xvld_reg, yvld_reg;
    logic                rdx_vld_reg, rdy_vld_reg;

    // burst sequencer
    logic             em_axis_reg;
    logic [IDX_W-1:0] em_idx_reg;
    logic             m_valid_reg, m_last_reg, m_axis_reg;
    logic [IDX_W-1:0] m_bin_reg;
    logic [SUM_W-1:0] m_sum_reg;

    // ram ports
    logic [IDX_W-1:0] rdx_addr, rdy_addr;
    logic [SUM_W-1:0] rdx_data, rdy_data;
    logic             wrx_en, wry_en;
    logic [SUM_W-1:0] x_new, y_new, x_old, y_old, v_ext;

    // current cell position and windows
    logic [IDX_W-1:0] xp, yp;
    logic [CMP_W-1:0] x1, y1;
    logic             x_in_phi, y_in_eta, y_wrap, grid_end, accept;
    logic             m_hs, em_x_done, em_last;

    assign accept = s_tvalid && s_tready;
    assign m_hs   = m_valid_reg && m_tready;

    always_comb begin
        xp = (CMP_W'(x_pos_reg) >= nx) ? IDX_W'(nx - CMP_W'(1)) : x_pos_reg;
        yp = (CMP_W'(y_pos_reg) >= ny) ? IDX_W'(ny - CMP_W'(1)) : y_pos_reg;
        x1 = CMP_W'(xp) + CMP_W'(1);
        y1 = CMP_W'(yp) + CMP_W'(1);
        x_in_phi = (x1 >= CMP_W'(cfg.phi_x_first)) && (x1 <= CMP_W'(cfg.phi_x_last));
        y_in_eta = (y1 >= CMP_W'(cfg.eta_y_first)) && (y1 <= CMP_W'(cfg.eta_y_last));
        y_wrap   = (y1 >= ny);
        grid_end = y_wrap && (x1 >= nx);
    end

    // read at the cell position while streaming, at the burst index otherwise
    assign rdx_addr = (state_reg == ST_IDLE) ? xp : em_idx_reg;
    assign rdy_addr = (state_reg == ST_IDLE) ? yp : em_idx_reg;

    // read-modify-write of stage 1
    always_comb begin
        v_ext = SUM_W'(s1_value_reg);
        if (fwdx_valid_reg && (fwdx_addr_reg == s1_xa_reg)) begin
            x_old = fwdx_data_reg;
        end else begin
            x_old = rdx_vld_reg ? rdx_data : '0;
        end
        if (fwdy_valid_reg && (fwdy_addr_reg == s1_ya_reg)) begin
            y_old = fwdy_data_reg;
        end else begin
            y_old = rdy_vld_reg ? rdy_data : '0;
        end
        x_new  = x_old + v_ext;
        y_new  = y_old + v_ext;
        wrx_en = s1_valid_reg && s1_x_en_reg;
        wry_en = s1_valid_reg && s1_y_en_reg;
    end

    wgp_ram #(.WIDTH(SUM_W), .DEPTH(MAX_BINS)) u_xsum (
        .aclk    (aclk),
        .wr_en   (wrx_en),
        .wr_addr (s1_xa_reg),
        .wr_data (x_new),
        .rd_addr (rdx_addr),
        .rd_data (rdx_data)
    );

    wgp_ram #(.WIDTH(SUM_W), .DEPTH(MAX_BINS)) u_ysum (
        .aclk    (aclk),
        .wr_en   (wry_en),
        .wr_addr (s1_ya_reg),
        .wr_data (y_new),
        .rd_addr (rdy_addr),
        .rd_data (rdy_data)
    );

    // burst bookkeeping
    assign em_x_done = (CMP_W'(em_idx_reg) + CMP_W'(1)) >= nx;
    assign em_last   = em_axis_reg && ((CMP_W'(em_idx_reg) + CMP_W'(1)) >= ny);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (accept && grid_end) state_next = ST_FLUSH;
            ST_FLUSH: state_next = ST_RD;
            ST_RD:    state_next = ST_LD;
            ST_LD:    state_next = ST_SEND;
            ST_SEND: begin
                if (m_hs) begin
                    state_next = m_last_reg ? ST_IDLE : ST_RD;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            x_pos_reg      <= '0;
            y_pos_reg      <= '0;
            s1_valid_reg   <= 1'b0;
            fwdx_valid_reg <= 1'b0;
            fwdy_valid_reg <= 1'b0;
            xvld_reg       <= '0;
            yvld_reg       <= '0;
            em_axis_reg    <= 1'b0;
            em_idx_reg     <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            s1_valid_reg   <= accept;
            fwdx_valid_reg <= wrx_en;
            fwdy_valid_reg <= wry_en;

            if (accept) begin
                if (grid_end) begin
                    x_pos_reg <= '0;
                    y_pos_reg <= '0;
                end else if (y_wrap) begin
                    x_pos_reg <= IDX_W'(x1);
                    y_pos_reg <= '0;
                end else begin
                    x_pos_reg <= xp;
                    y_pos_reg <= IDX_W'(y1);
                end
            end

            if (wrx_en) begin
                xvld_reg[s1_xa_reg] <= 1'b1;
            end
            if (wry_en) begin
                yvld_reg[s1_ya_reg] <= 1'b1;
            end

            if (state_reg == ST_LD) begin
                m_valid_reg <= 1'b1;
            end else if (m_hs) begin
                m_valid_reg <= 1'b0;
            end

            if (m_hs) begin
                if (m_last_reg) begin
                    // grid done: every entry reads as zero again
                    xvld_reg    <= '0;
                    yvld_reg    <= '0;
                    em_axis_reg <= 1'b0;
                    em_idx_reg  <= '0;
                end else if (!em_axis_reg && em_x_done) begin
                    em_axis_reg <= 1'b1;
                    em_idx_reg  <= '0;
                end else begin
                    em_idx_reg  <= em_idx_reg + IDX_W'(1);
                end
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        rdx_vld_reg <= xvld_reg[rdx_addr];
        rdy_vld_reg <= yvld_reg[rdy_addr];
        if (accept) begin
            s1_xa_reg    <= xp;
            s1_ya_reg    <= yp;
            s1_x_en_reg  <= y_in_eta;
            s1_y_en_reg  <= x_in_phi;
            s1_value_reg <= s_tdata[VALUE_WIDTH-1:0];
        end
        fwdx_addr_reg <= s1_xa_reg;
        fwdx_data_reg <= x_new;
        fwdy_addr_reg <= s1_ya_reg;
        fwdy_data_reg <= y_new;
        if (state_reg == ST_LD) begin
            m_axis_reg <= em_axis_reg;
            m_bin_reg  <= em_idx_reg;
            m_last_reg <= em_last;
            if (em_axis_reg) begin
                m_sum_reg <= rdy_vld_reg ? rdy_data : '0;
            end else begin
                m_sum_reg <= rdx_vld_reg ? rdx_data : '0;
            end
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_axis_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, m_sum_reg, wgp_pkg::BIN_W'(m_bin_reg)};

    // no cell is taken while a result is on offer
    a_no_input_during_burst: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !s_tready)
        else $error("cell taken while a result is pending");

    // the grid's final cell always leads into the flush cycle
    a_final_cell_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && grid_end) |=> (state_reg == ST_FLUSH))
        else $error("final cell did not start the burst");

    // no accumulation write overlaps a burst read
    a_no_rmw_in_burst: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RD || state_reg == ST_LD || state_reg == ST_SEND)
            |-> !s1_valid_reg)
        else $error("accumulation still active during burst");

    // the last result of a burst is a row sum
    a_last_is_row: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_last_reg) |-> m_axis_reg)
        else $error("burst ended on a column sum");

    // store reads as empty once the burst completes
    a_store_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_hs && m_last_reg) |=> (xvld_reg == '0 && yvld_reg == '0
            && state_reg == ST_IDLE))
        else $error("store not cleared after burst");

endmodule
